[rtl/lpps_pkg.sv]
package lpps_pkg;

   localparam int TIMER_W   = 16;
   localparam int COUNT_W   = 8;
   localparam int LEVEL_W   = 8;
   localparam int CAL_W     = 8;
   localparam int INDEX_W   = 5;
   localparam int ENTRY_W   = 4;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 8;

   localparam logic [TIMER_W-1:0] TIMER_TOP = '1;
   localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
   localparam logic [INDEX_W-1:0] INDEX_TOP = '1;

   localparam logic [CAL_W-1:0]   CAL_RESET   = 8'd255;
   localparam logic [INDEX_W-1:0] COUNT_RESET = 5'd1;

   typedef enum logic [1:0] {
      MODE_OFFSET = 2'd0,
      MODE_HIGH   = 2'd1,
      MODE_LOW    = 2'd2,
      MODE_DONE   = 2'd3
   } mode_type;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CALIBRATION = 4'd0,
      CSR_PHASE_COUNT = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [TIMER_W-1:0] offset;
      logic [TIMER_W-1:0] pulse;
      logic [TIMER_W-1:0] gap;
      logic [COUNT_W-1:0] repeat_n;
      logic [LEVEL_W-1:0] level;
   } phase_entry_type;

   localparam int ENTRY_BITS = $bits(phase_entry_type);

endpackage

[rtl/lpps_ram.sv]
module lpps_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/led_phase_pulse_sequencer.sv]
// Steps one LED through up to MAX_PHASES programmed phases (offset, pulses, gaps).
// A write transfer stores a phase entry in the table RAM. A tick transfer passes
// through the registered table read at the current phase and then the update of
// mode, timer, counters and the result; requests stall while a tick is in the
// update stage. Each tick returns one result (calibrated intensity and finished
// flag) through an output register; a tick whose result meets a full, stalled
// output register waits in the update stage until it drains.
// Writes to unwritten table entries must precede any tick that reaches them.
module led_phase_pulse_sequencer
   import lpps_pkg::*;
#(
   parameter int MAX_PHASES = 16
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic [ENTRY_W-1:0]   req_entry_index,
   input  logic [TIMER_W-1:0]   req_offset_ticks,
   input  logic [TIMER_W-1:0]   req_pulse_ticks,
   input  logic [TIMER_W-1:0]   req_gap_ticks,
   input  logic [COUNT_W-1:0]   req_repeat_count,
   input  logic [LEVEL_W-1:0]   req_level,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [LEVEL_W-1:0]   rsp_intensity,
   output logic                 rsp_finished,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int AW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
   localparam int LIM_W = 10;
   localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_PHASES);

   logic [CAL_W-1:0]   cal_ff, cal_in;
   logic [INDEX_W-1:0] count_ff, count_in;

   mode_type           mode_ff, mode_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [COUNT_W-1:0] pulses_ff, pulses_in;

   logic               exec_valid_ff, exec_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_intensity_ff, rsp_intensity_in;
   logic               rsp_finished_ff, rsp_finished_in;

   logic               req_take;
   logic               tick_take;
   logic               wr_en;
   logic               exec_done;
   phase_entry_type    wr_entry;
   phase_entry_type    rd_entry;
   logic [ENTRY_BITS-1:0] rd_bits;

   logic [TIMER_W-1:0] timer_inc;
   logic [COUNT_W-1:0] pulses_inc;
   logic [INDEX_W-1:0] index_inc;
   logic [15:0]        product;
   logic [LEVEL_W-1:0] scaled;
   logic               last_phase;

   assign req_take  = req_valid && !req_stall;
   assign tick_take = req_take && (cmd_type'(req_cmd) == CMD_TICK);
   assign wr_en     = req_take && (cmd_type'(req_cmd) == CMD_WRITE)
                      && (LIM_W'(req_entry_index) < MAX_LIM);
   assign req_stall = exec_valid_ff;
   assign exec_done = exec_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   assign wr_entry = '{offset:   req_offset_ticks,
                       pulse:    req_pulse_ticks,
                       gap:      req_gap_ticks,
                       repeat_n: req_repeat_count,
                       level:    req_level};

   lpps_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_PHASES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (wr_entry),
      .rd_en   (tick_take),
      .rd_addr (AW'(index_ff)),
      .rd_data (rd_bits)
   );

   assign rd_entry = phase_entry_type'(rd_bits);

   always_comb begin
      cal_in   = cal_ff;
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CALIBRATION: cal_in   = csr_wdata[CAL_W-1:0];
            CSR_PHASE_COUNT: count_in = csr_wdata[INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      timer_inc  = (timer_ff == TIMER_TOP) ? timer_ff : timer_ff + 1'b1;
      pulses_inc = (pulses_ff == COUNT_TOP) ? pulses_ff : pulses_ff + 1'b1;
      index_inc  = (index_ff == INDEX_TOP) ? index_ff : index_ff + 1'b1;
      product    = 16'(rd_entry.level) * 16'(cal_ff);
      scaled     = product[15:8];
      last_phase = (index_inc >= count_ff) || (LIM_W'(index_inc) >= MAX_LIM);

      mode_in          = mode_ff;
      index_in         = index_ff;
      timer_in         = timer_ff;
      pulses_in        = pulses_ff;
      rsp_intensity_in = rsp_intensity_ff;
      rsp_finished_in  = rsp_finished_ff;
      exec_valid_in    = exec_valid_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;

      if (tick_take) begin
         exec_valid_in = 1'b1;
      end

      if (exec_done) begin
         exec_valid_in    = 1'b0;
         rsp_valid_in     = 1'b1;
         rsp_intensity_in = '0;
         timer_in         = timer_inc;
         unique case (mode_ff)
            MODE_OFFSET: begin
               if (timer_inc >= rd_entry.offset) begin
                  mode_in          = MODE_HIGH;
                  timer_in         = '0;
                  rsp_intensity_in = scaled;
               end
            end
            MODE_HIGH: begin
               if (timer_inc >= rd_entry.pulse) begin
                  mode_in  = MODE_LOW;
                  timer_in = '0;
               end else begin
                  rsp_intensity_in = scaled;
               end
            end
            MODE_LOW: begin
               if (timer_inc >= rd_entry.gap) begin
                  timer_in  = '0;
                  pulses_in = pulses_inc;
                  if (pulses_inc >= rd_entry.repeat_n) begin
                     index_in = index_inc;
                     if (last_phase) begin
                        mode_in = MODE_DONE;
                     end else begin
                        mode_in   = MODE_OFFSET;
                        pulses_in = '0;
                     end
                  end else begin
                     mode_in          = MODE_HIGH;
                     rsp_intensity_in = scaled;
                  end
               end
            end
            MODE_DONE: ;
            default: ;
         endcase
         rsp_finished_in = (mode_in == MODE_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff        <= CAL_RESET;
         count_ff      <= COUNT_RESET;
         mode_ff       <= MODE_OFFSET;
         index_ff      <= '0;
         timer_ff      <= '0;
         pulses_ff     <= '0;
         exec_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cal_ff        <= cal_in;
         count_ff      <= count_in;
         mode_ff       <= mode_in;
         index_ff      <= index_in;
         timer_ff      <= timer_in;
         pulses_ff     <= pulses_in;
         exec_valid_ff <= exec_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_intensity_ff <= rsp_intensity_in;
      rsp_finished_ff  <= rsp_finished_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_intensity = rsp_intensity_ff;
   assign rsp_finished  = rsp_finished_ff;

endmodule

[verif/tb_top.sv]
module tb_top
   import lpps_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES      = 16;
   localparam int ITEMS       = 1475;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int PAUSE       = 8;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic [LEVEL_W-1:0] intensity;
      logic               finished;
   } led_out_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [ENTRY_W-1:0] entry;
      phase_entry_type    fields;
   } phase_req_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_SPARSE,
      STALL_HALF,
      STALL_BLOCK
   } stall_kind_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_cmd = 1'b0;
   logic [ENTRY_W-1:0]   req_entry_index = '0;
   logic [TIMER_W-1:0]   req_offset_ticks = '0;
   logic [TIMER_W-1:0]   req_pulse_ticks = '0;
   logic [TIMER_W-1:0]   req_gap_ticks = '0;
   logic [COUNT_W-1:0]   req_repeat_count = '0;
   logic [LEVEL_W-1:0]   req_level = '0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [LEVEL_W-1:0]   rsp_intensity;
   logic                 rsp_finished;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   mode_type             seq_mode;
   logic [INDEX_W-1:0]   seq_phase;
   logic [TIMER_W-1:0]   seq_ticks;
   logic [COUNT_W-1:0]   seq_pulses;
   logic [CAL_W-1:0]     seq_cal;
   logic [INDEX_W-1:0]   seq_count;
   phase_entry_type      seq_table [PHASES];

   led_out_type          led_expected [$];
   int unsigned          mismatches = 0;
   int unsigned          cycle_count = 0;
   int                   burst_left = 0;
   stall_kind_type       stall_kind = STALL_NONE;
   int                   stall_left = 0;

   led_phase_pulse_sequencer #(
      .MAX_PHASES(PHASES)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_entry_index  (req_entry_index),
      .req_offset_ticks (req_offset_ticks),
      .req_pulse_ticks  (req_pulse_ticks),
      .req_gap_ticks    (req_gap_ticks),
      .req_repeat_count (req_repeat_count),
      .req_level        (req_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_intensity    (rsp_intensity),
      .rsp_finished     (rsp_finished),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_kind <= stall_kind_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(1, 48);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_kind)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_SPARSE: rsp_stall <= ($urandom_range(0, 7) == 0);
         STALL_HALF:   rsp_stall <= ($urandom_range(0, 1) == 1);
         default:      rsp_stall <= (stall_left < 6);
      endcase
   end

   function automatic void flag_mismatch(input string what, input logic [15:0] want,
                                         input logic [15:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d: %s expected %0h, got %0h",
                  cycle_count, what, want, got);
   endfunction

   always @(posedge clock) begin
      led_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (led_expected.size() == 0) begin
            flag_mismatch("unexpected result, intensity", 16'h0, 16'(rsp_intensity));
         end else begin
            want = led_expected.pop_front();
            if (rsp_intensity !== want.intensity)
               flag_mismatch("intensity", 16'(want.intensity), 16'(rsp_intensity));
            if (rsp_finished !== want.finished)
               flag_mismatch("finished", 16'(want.finished), 16'(rsp_finished));
         end
      end
   end

   function automatic bit step_sequencer(input phase_req_type it, output led_out_type res);
      phase_entry_type    cur;
      logic [INDEX_W-1:0] limit;
      logic [LEVEL_W-1:0] lit;
      res = '0;
      if (it.cmd == CMD_WRITE) begin
         seq_table[it.entry] = it.fields;
         return 1'b0;
      end
      limit = (seq_count > PHASES) ? INDEX_W'(PHASES) : seq_count;
      if (seq_ticks != TIMER_TOP)
         seq_ticks = seq_ticks + 1'b1;
      cur = (seq_phase < PHASES) ? seq_table[seq_phase[ENTRY_W-1:0]] : '0;
      lit = LEVEL_W'((16'(cur.level) * 16'(seq_cal)) >> 8);
      case (seq_mode)
         MODE_OFFSET: begin
            if (seq_ticks >= cur.offset) begin
               seq_mode = MODE_HIGH;
               seq_ticks = '0;
               res.intensity = lit;
            end
         end
         MODE_HIGH: begin
            if (seq_ticks >= cur.pulse) begin
               seq_mode = MODE_LOW;
               seq_ticks = '0;
            end else begin
               res.intensity = lit;
            end
         end
         MODE_LOW: begin
            if (seq_ticks >= cur.gap) begin
               seq_ticks = '0;
               if (seq_pulses != COUNT_TOP)
                  seq_pulses = seq_pulses + 1'b1;
               if (seq_pulses >= cur.repeat_n) begin
                  if (seq_phase != INDEX_TOP)
                     seq_phase = seq_phase + 1'b1;
                  if (seq_phase >= limit) begin
                     seq_mode = MODE_DONE;
                  end else begin
                     seq_mode = MODE_OFFSET;
                     seq_pulses = '0;
                  end
               end else begin
                  seq_mode = MODE_HIGH;
                  res.intensity = lit;
               end
            end
         end
         default: ;
      endcase
      res.finished = (seq_mode == MODE_DONE);
      return 1'b1;
   endfunction

   function automatic logic [TIMER_W-1:0] short_ticks();
      return ($urandom_range(0, 9) < 7) ? TIMER_W'($urandom_range(0, 7))
                                        : TIMER_W'($urandom_range(8, 60));
   endfunction

   function automatic phase_entry_type short_entry();
      phase_entry_type e;
      e.offset   = short_ticks();
      e.pulse    = short_ticks();
      e.gap      = short_ticks();
      e.repeat_n = COUNT_W'($urandom_range(0, 10));
      e.level    = LEVEL_W'($urandom);
      return e;
   endfunction

   function automatic phase_entry_type full_entry();
      return phase_entry_type'({$urandom, $urandom});
   endfunction

   function automatic phase_req_type write_req(input int entry, input phase_entry_type e);
      phase_req_type r;
      r.cmd    = CMD_WRITE;
      r.entry  = ENTRY_W'(entry);
      r.fields = e;
      return r;
   endfunction

   function automatic phase_req_type tick_req();
      phase_req_type r;
      r.cmd    = CMD_TICK;
      r.entry  = ENTRY_W'($urandom);
      r.fields = full_entry();
      return r;
   endfunction

   task automatic send_item(input phase_req_type it);
      int          gap;
      led_out_type res;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid        <= 1'b1;
      req_cmd          <= it.cmd;
      req_entry_index  <= it.entry;
      req_offset_ticks <= it.fields.offset;
      req_pulse_ticks  <= it.fields.pulse;
      req_gap_ticks    <= it.fields.gap;
      req_repeat_count <= it.fields.repeat_n;
      req_level        <= it.fields.level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      if (step_sequencer(it, res))
         led_expected.push_back(res);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data,
                            input bit more);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_CALIBRATION)
         seq_cal = data;
      else if (idx == CSR_PHASE_COUNT)
         seq_count = data[INDEX_W-1:0];
      if (!more)
         csr_valid <= 1'b0;
   endtask

   // drop the request, drain every result, then let the pipeline go quiet
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (led_expected.size() != 0) @(posedge clock);
      repeat (PAUSE) @(posedge clock);
   endtask

   task automatic test_register_extremes();
      settle();
      write_csr(CSR_PHASE_COUNT, CSR_DAT_W'(31), 1'b1);
      write_csr(CSR_IDX_W'(2), CSR_DAT_W'(255), 1'b1);
      write_csr(CSR_IDX_W'(15), CSR_DAT_W'(0), 1'b1);
      write_csr(CSR_CALIBRATION, CSR_DAT_W'(255), 1'b0);
   endtask

   task automatic test_fill_table();
      phase_entry_type e;
      e = '0;
      e.level = '1;
      send_item(write_req(0, e));
      for (int i = 1; i < PHASES; i++)
         send_item(write_req(i, short_entry()));
   endtask

   task automatic test_calibration();
      logic [CAL_W-1:0] cal_set [4] = '{8'd0, 8'd255, 8'd1, 8'd128};
      phase_entry_type  e;
      e = '0;
      e.pulse = 16'd40;
      e.level = '1;
      send_item(write_req(int'(seq_phase), e));
      foreach (cal_set[i]) begin
         settle();
         write_csr(CSR_CALIBRATION, cal_set[i], 1'b0);
         repeat (2) send_item(tick_req());
      end
   endtask

   task automatic test_long_offset();
      phase_entry_type    e;
      logic [INDEX_W-1:0] target;
      int                 n;
      target = seq_phase + 1'b1;
      e = '0;
      e.level = LEVEL_W'($urandom);
      send_item(write_req(int'(seq_phase), e));
      e.offset   = 16'd200;
      e.pulse    = 16'd1;
      e.repeat_n = 8'd1;
      e.level    = '1;
      send_item(write_req(int'(target), e));
      n = 0;
      while (!(seq_phase == target && seq_mode != MODE_OFFSET) && n < 1000) begin
         send_item(tick_req());
         n++;
      end
   endtask

   task automatic test_random();
      int                 phase_now;
      int                 pick;
      bit                 extra;
      logic [CAL_W-1:0]   cal;
      logic [INDEX_W-1:0] cnt;
      for (int n = 0; n < ITEMS; n++) begin
         if (n % 150 == 149) begin
            settle();
            pick = $urandom_range(0, 3);
            cal = (pick == 0) ? CAL_W'(0) : (pick == 1) ? CAL_W'(255) : CAL_W'($urandom);
            write_csr(CSR_CALIBRATION, cal, 1'b1);
            if (seq_phase < 15)
               cnt = INDEX_W'($urandom_range(int'(seq_phase) + 2, 31));
            else
               cnt = INDEX_TOP;
            extra = ($urandom_range(0, 1) == 1);
            write_csr(CSR_PHASE_COUNT, {3'($urandom), cnt}, extra);
            if (extra)
               write_csr(CSR_IDX_W'($urandom_range(2, 15)), CSR_DAT_W'($urandom), 1'b0);
         end
         phase_now = int'(seq_phase);
         if ($urandom_range(0, 3) != 0)
            send_item(tick_req());
         else if (phase_now >= PHASES || (phase_now > 0 && $urandom_range(0, 1) == 1))
            send_item(write_req($urandom_range(0, (phase_now >= PHASES) ? PHASES - 1
                                                                       : phase_now - 1),
                                full_entry()));
         else
            send_item(write_req($urandom_range(phase_now, (phase_now + 2 >= PHASES) ? PHASES - 1
                                                                                    : phase_now + 2),
                                short_entry()));
      end
   endtask

   task automatic test_end_sequence();
      phase_entry_type e;
      int              n;
      settle();
      write_csr(CSR_PHASE_COUNT, CSR_DAT_W'(0), 1'b0);
      if (seq_phase < PHASES) begin
         e = '0;
         e.level = LEVEL_W'($urandom);
         send_item(write_req(int'(seq_phase), e));
      end
      n = 0;
      while (seq_mode != MODE_DONE && n < 1000) begin
         send_item(tick_req());
         n++;
      end
      repeat (40) begin
         if ($urandom_range(0, 2) != 0)
            send_item(tick_req());
         else
            send_item(write_req($urandom_range(0, PHASES - 1), full_entry()));
      end
   endtask

   initial begin
      seq_mode   = MODE_OFFSET;
      seq_phase  = '0;
      seq_ticks  = '0;
      seq_pulses = '0;
      seq_cal    = CAL_RESET;
      seq_count  = COUNT_RESET;
      foreach (seq_table[i])
         seq_table[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_register_extremes();
      test_fill_table();
      test_calibration();
      test_long_offset();
      test_random();
      test_end_sequence();

      req_valid <= 1'b0;
      while (led_expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[filelist.f]
rtl/lpps_pkg.sv
rtl/lpps_ram.sv
rtl/led_phase_pulse_sequencer.sv
verif/tb_top.sv
